/* sv/pfe_pkg.sv */
// Package of the palette fade engine: word types, opcodes, register indexes,
// controller command and state types, and the fade colour scaling function.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package pfe_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int DIV_STAGES = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 3'd5;

    typedef enum logic [2:0] {
        OP_WR_CUR    = 3'd0,
        OP_WR_TGT    = 3'd1,
        OP_RD        = 3'd2,
        OP_START_OUT = 3'd3,
        OP_START_IN  = 3'd4,
        OP_FRAME     = 3'd5,
        OP_FINISH    = 3'd6
    } t_opcode;

    typedef enum logic [2:0] {
        CMD_WR_CUR,
        CMD_WR_TGT,
        CMD_RD,
        CMD_COPY_ORG,
        CMD_COPY_TGT,
        CMD_FILL,
        CMD_FRAME
    } t_cmd_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] entry_index;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] frame_index;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       is_faded;
        logic       status;
    } t_out_word;

    typedef struct packed {
        logic      issue;
        t_cmd_kind kind;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_dp_stat;

    // v * 255 / 63 equals 4v plus v / 21 for six-bit v.
    function automatic logic [7:0] scale6(input logic [5:0] v);
        logic [1:0] q;
        q = (v >= 6'd63) ? 2'd3 : (v >= 6'd42) ? 2'd2 : (v >= 6'd21) ? 2'd1 : 2'd0;
        return {v, 2'b00} + {6'd0, q};
    endfunction

endpackage

`default_nettype wire

/* sv/pfe_datapath.sv */
// Datapath of the palette fade engine: the three palette memories, the entry
// valid bits and the interpolation pipeline with its eight-stage divider.
// Depends on pfe_pkg.
`default_nettype none

module pfe_datapath #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pfe_pkg::t_cmd                      i_cmd,
    input  wire logic [$clog2(PALETTE_ENTRIES)-1:0] i_addr,
    input  wire logic [23:0]                        i_wr_col,
    input  wire logic [7:0]                         i_frame,
    input  wire logic [7:0]                         i_steps,
    input  wire logic                               i_fade_in,
    input  wire logic [23:0]                        i_fade_col,
    output pfe_pkg::t_dp_stat                       o_stat,
    output logic [23:0]                             o_rd_col
);

    localparam int AW  = $clog2(PALETTE_ENTRIES);
    localparam int DIV = pfe_pkg::DIV_STAGES;

    logic [23:0] r_cur_mem [PALETTE_ENTRIES];
    logic [23:0] r_tgt_mem [PALETTE_ENTRIES];
    logic [23:0] r_org_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_cur_vld;

    logic [23:0] r_cur_q, r_tgt_q, r_org_q;
    logic        r_cvq;

    logic                 r_s1_v;
    pfe_pkg::t_cmd_kind   r_s1_kind;
    logic [AW-1:0]        r_s1_addr;

    logic          r_a_v;
    logic [AW-1:0] r_a_addr;
    logic [23:0]   r_a_org;
    logic [7:0]    r_a_mag [3];
    logic [2:0]    r_a_neg;

    logic          r_m_v;
    logic [AW-1:0] r_m_addr;
    logic [23:0]   r_m_org;
    logic [15:0]   r_m_prod [3];
    logic [2:0]    r_m_neg;

    logic [DIV-1:0] r_d_v;
    logic [AW-1:0]  r_d_addr [DIV];
    logic [23:0]    r_d_org  [DIV];
    logic [2:0]     r_d_neg  [DIV];
    logic [7:0]     r_d_rem  [DIV][3];
    logic [7:0]     r_d_low  [DIV][3];
    logic [7:0]     r_d_quo  [DIV][3];

    logic [23:0]   cur_rd;
    logic [23:0]   goal;
    logic [8:0]    diff [3];
    logic [7:0]    mag  [3];
    logic [2:0]    neg;
    logic [23:0]   res;
    logic          cw_en;
    logic [AW-1:0] cw_addr;
    logic [23:0]   cw_data;
    logic [23:0]   r_rd_col;

    function automatic logic [23:0] div_step(input logic [7:0] rem, input logic [7:0] low,
                                             input logic [7:0] quo, input logic [7:0] d);
        logic [8:0] t;
        logic [8:0] s;
        t = {rem, low[7]};
        s = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {s[7:0], low[6:0], 1'b0, quo[6:0], 1'b1};
        end
        return {t[7:0], low[6:0], 1'b0, quo[6:0], 1'b0};
    endfunction

    assign cur_rd = r_cvq ? r_cur_q : 24'd0;
    assign goal   = i_fade_in ? r_tgt_q : i_fade_col;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            diff[c] = {1'b0, goal[8*c +: 8]} - {1'b0, r_org_q[8*c +: 8]};
            neg[c]  = diff[c][8];
            mag[c]  = diff[c][8] ? 8'(-diff[c]) : diff[c][7:0];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_d_neg[DIV-1][c]) begin
                res[8*c +: 8] = r_d_org[DIV-1][8*c +: 8] - r_d_quo[DIV-1][c];
            end else begin
                res[8*c +: 8] = r_d_org[DIV-1][8*c +: 8] + r_d_quo[DIV-1][c];
            end
        end
    end

    always_comb begin
        cw_en   = 1'b0;
        cw_addr = i_addr;
        cw_data = i_wr_col;
        if (i_cmd.issue && (i_cmd.kind == pfe_pkg::CMD_WR_CUR
                            || i_cmd.kind == pfe_pkg::CMD_FILL)) begin
            cw_en = 1'b1;
        end else if (r_s1_v && r_s1_kind == pfe_pkg::CMD_COPY_TGT) begin
            cw_en   = 1'b1;
            cw_addr = r_s1_addr;
            cw_data = r_tgt_q;
        end else if (r_d_v[DIV-1]) begin
            cw_en   = 1'b1;
            cw_addr = r_d_addr[DIV-1];
            cw_data = res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_q <= r_cur_mem[i_addr];
        r_tgt_q <= r_tgt_mem[i_addr];
        r_org_q <= r_org_mem[i_addr];
        r_cvq   <= r_cur_vld[i_addr];
        if (cw_en) begin
            r_cur_mem[cw_addr] <= cw_data;
        end
        if (i_cmd.issue && i_cmd.kind == pfe_pkg::CMD_WR_TGT) begin
            r_tgt_mem[i_addr] <= i_wr_col;
        end
        if (r_s1_v && r_s1_kind == pfe_pkg::CMD_COPY_ORG) begin
            r_org_mem[r_s1_addr] <= cur_rd;
        end
        if (r_s1_v && r_s1_kind == pfe_pkg::CMD_RD) begin
            r_rd_col <= cur_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= '0;
            r_s1_v    <= 1'b0;
            r_a_v     <= 1'b0;
            r_m_v     <= 1'b0;
            r_d_v     <= '0;
        end else begin
            if (cw_en) begin
                r_cur_vld[cw_addr] <= 1'b1;
            end
            r_s1_v <= i_cmd.issue;
            r_a_v  <= r_s1_v && r_s1_kind == pfe_pkg::CMD_FRAME;
            r_m_v  <= r_a_v;
            r_d_v  <= {r_d_v[DIV-2:0], r_m_v};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_kind <= i_cmd.kind;
        r_s1_addr <= i_addr;
        r_a_addr  <= r_s1_addr;
        r_a_org   <= r_org_q;
        r_a_neg   <= neg;
        r_m_addr  <= r_a_addr;
        r_m_org   <= r_a_org;
        r_m_neg   <= r_a_neg;
        for (int c = 0; c < 3; c++) begin
            r_a_mag[c]  <= mag[c];
            r_m_prod[c] <= {8'd0, r_a_mag[c]} * {8'd0, i_frame};
            {r_d_rem[0][c], r_d_low[0][c], r_d_quo[0][c]} <=
                div_step(r_m_prod[c][15:8], r_m_prod[c][7:0], 8'd0, i_steps);
        end
        r_d_addr[0] <= r_m_addr;
        r_d_org[0]  <= r_m_org;
        r_d_neg[0]  <= r_m_neg;
        for (int k = 1; k < DIV; k++) begin
            r_d_addr[k] <= r_d_addr[k-1];
            r_d_org[k]  <= r_d_org[k-1];
            r_d_neg[k]  <= r_d_neg[k-1];
            for (int c = 0; c < 3; c++) begin
                {r_d_rem[k][c], r_d_low[k][c], r_d_quo[k][c]} <=
                    div_step(r_d_rem[k-1][c], r_d_low[k-1][c], r_d_quo[k-1][c], i_steps);
            end
        end
    end

    assign o_stat.busy = r_s1_v | r_a_v | r_m_v | (|r_d_v);
    assign o_rd_col    = r_rd_col;

endmodule

`default_nettype wire

/* sv/pfe_ctrl.sv */
// Controller of the palette fade engine: decodes each input word, sweeps the
// entry addresses for the datapath and holds the result word for the output.
// Depends on pfe_pkg.
`default_nettype none

module pfe_ctrl #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire pfe_pkg::t_in_word                  i_in_word,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output pfe_pkg::t_out_word                      o_out_word,
    input  wire logic [7:0]                         i_fade_first,
    input  wire logic [7:0]                         i_fade_last,
    input  wire logic [7:0]                         i_fade_steps,
    input  wire logic [23:0]                        i_fade_col,
    output pfe_pkg::t_cmd                           o_cmd,
    output logic [$clog2(PALETTE_ENTRIES)-1:0]      o_addr,
    output logic [23:0]                             o_wr_col,
    output logic [7:0]                              o_frame,
    output logic                                    o_fade_in,
    input  wire pfe_pkg::t_dp_stat                  i_stat,
    input  wire logic [23:0]                        i_rd_col
);

    localparam int         AW        = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] LAST_ENT9 = 9'(PALETTE_ENTRIES - 1);

    pfe_pkg::t_state    r_state, n_state;
    pfe_pkg::t_in_word  r_item;
    pfe_pkg::t_cmd_kind r_kind, n_kind;
    logic [AW-1:0]      r_addr, n_addr, r_end, n_end;
    logic               r_fade_in, n_fade_in, r_faded, n_faded;
    logic               r_status, n_status, r_rd_hit, n_rd_hit;
    logic               n_run;
    logic               r_out_valid;
    pfe_pkg::t_out_word r_out_word;
    logic               accept, slot_free, idx_ok, first_ok;
    logic [8:0]         end9;
    logic [23:0]        rd;

    assign accept    = (r_state == pfe_pkg::ST_IDLE) && i_valid;
    assign slot_free = !r_out_valid || i_ready;
    assign idx_ok    = {1'b0, i_in_word.entry_index} <= LAST_ENT9;
    assign first_ok  = {1'b0, i_fade_first} <= LAST_ENT9;
    assign end9      = ({1'b0, i_fade_last} > LAST_ENT9) ? LAST_ENT9 : {1'b0, i_fade_last};

    always_comb begin
        n_kind    = pfe_pkg::CMD_WR_CUR;
        n_addr    = i_in_word.entry_index[AW-1:0];
        n_end     = i_in_word.entry_index[AW-1:0];
        n_run     = 1'b0;
        n_fade_in = r_fade_in;
        n_faded   = r_faded;
        n_status  = 1'b0;
        n_rd_hit  = 1'b0;
        unique case (pfe_pkg::t_opcode'(i_in_word.opcode)) inside
            pfe_pkg::OP_WR_CUR: begin
                n_run = idx_ok;
            end
            pfe_pkg::OP_WR_TGT: begin
                n_kind = pfe_pkg::CMD_WR_TGT;
                n_run  = idx_ok;
            end
            pfe_pkg::OP_RD: begin
                n_kind   = pfe_pkg::CMD_RD;
                n_run    = idx_ok;
                n_rd_hit = idx_ok;
            end
            pfe_pkg::OP_START_OUT, pfe_pkg::OP_START_IN: begin
                n_kind    = pfe_pkg::CMD_COPY_ORG;
                n_addr    = '0;
                n_end     = LAST_ENT9[AW-1:0];
                n_run     = 1'b1;
                n_fade_in = (i_in_word.opcode == pfe_pkg::OP_START_IN);
            end
            pfe_pkg::OP_FRAME: begin
                n_kind = pfe_pkg::CMD_FRAME;
                n_addr = i_fade_first[AW-1:0];
                n_end  = end9[AW-1:0];
                if (i_in_word.frame_index >= i_fade_steps) begin
                    n_status = 1'b1;
                end else begin
                    n_run = first_ok && (i_fade_first <= i_fade_last);
                end
            end
            pfe_pkg::OP_FINISH: begin
                n_kind  = r_fade_in ? pfe_pkg::CMD_COPY_TGT : pfe_pkg::CMD_FILL;
                n_addr  = '0;
                n_end   = LAST_ENT9[AW-1:0];
                n_run   = 1'b1;
                n_faded = !r_fade_in;
            end
            default: begin
                n_run = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfe_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = n_run ? pfe_pkg::ST_RUN : pfe_pkg::ST_DRAIN;
                end
            end
            pfe_pkg::ST_RUN: begin
                if (r_addr == r_end) begin
                    n_state = pfe_pkg::ST_DRAIN;
                end
            end
            pfe_pkg::ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = pfe_pkg::ST_DONE;
                end
            end
            pfe_pkg::ST_DONE: begin
                if (slot_free) begin
                    n_state = pfe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready     = (r_state == pfe_pkg::ST_IDLE);
        o_cmd.issue = (r_state == pfe_pkg::ST_RUN);
        o_cmd.kind  = r_kind;
    end

    assign o_addr    = r_addr;
    assign o_wr_col  = (r_kind == pfe_pkg::CMD_FILL) ? i_fade_col
                     : {r_item.in_red, r_item.in_green, r_item.in_blue};
    assign o_frame   = r_item.frame_index;
    assign o_fade_in = r_fade_in;
    assign rd        = r_rd_hit ? i_rd_col : 24'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfe_pkg::ST_IDLE;
            r_fade_in   <= 1'b0;
            r_faded     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_fade_in <= n_fade_in;
                r_faded   <= n_faded;
            end
            if (r_state == pfe_pkg::ST_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item   <= i_in_word;
            r_kind   <= n_kind;
            r_addr   <= n_addr;
            r_end    <= n_end;
            r_status <= n_status;
            r_rd_hit <= n_rd_hit;
        end else if (r_state == pfe_pkg::ST_RUN) begin
            r_addr <= r_addr + 1'b1;
        end
        if (r_state == pfe_pkg::ST_DONE && slot_free) begin
            r_out_word.out_red   <= rd[23:16];
            r_out_word.out_green <= rd[15:8];
            r_out_word.out_blue  <= rd[7:0];
            r_out_word.is_faded  <= r_faded;
            r_out_word.status    <= r_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_word = r_out_word;

endmodule

`default_nettype wire

/* sv/palette_fade_engine_top.sv */
// A fade frame sweeps its configured entry range; start and finish sweep all
// PALETTE_ENTRIES entries, one entry a cycle through a single memory port.
// The divider is an eight-stage pipeline, so entries of a frame stream one a cycle.
// Synchronous active-low reset clears the palette (per-entry valid bits) and flags,
// and presets the configuration registers to their defaults.
// Top level: configuration registers, controller and datapath; depends on pfe_pkg.
`default_nettype none

module palette_fade_engine_top #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire pfe_pkg::t_in_word                i_in_word,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output pfe_pkg::t_out_word                    o_out_word,
    input  wire logic                             i_cfg_we,
    input  wire logic [pfe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pfe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [7:0]        r_fade_first, r_fade_last, r_fade_steps;
    logic [5:0]        r_fade_red, r_fade_green, r_fade_blue;
    logic [23:0]       fade_col;
    pfe_pkg::t_cmd     cmd;
    pfe_pkg::t_dp_stat stat;
    logic [AW-1:0]     addr;
    logic [23:0]       wr_col, rd_col;
    logic [7:0]        frame;
    logic              fade_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_first <= 8'd0;
            r_fade_last  <= 8'd255;
            r_fade_steps <= 8'd30;
            r_fade_red   <= 6'd0;
            r_fade_green <= 6'd0;
            r_fade_blue  <= 6'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfe_pkg::CFG_FIRST: r_fade_first <= i_cfg_data;
                pfe_pkg::CFG_LAST:  r_fade_last  <= i_cfg_data;
                pfe_pkg::CFG_STEPS: r_fade_steps <= i_cfg_data;
                pfe_pkg::CFG_RED:   r_fade_red   <= i_cfg_data[5:0];
                pfe_pkg::CFG_GREEN: r_fade_green <= i_cfg_data[5:0];
                pfe_pkg::CFG_BLUE:  r_fade_blue  <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    assign fade_col = {pfe_pkg::scale6(r_fade_red), pfe_pkg::scale6(r_fade_green),
                       pfe_pkg::scale6(r_fade_blue)};

    pfe_ctrl #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_word   (i_in_word),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_word  (o_out_word),
        .i_fade_first(r_fade_first),
        .i_fade_last (r_fade_last),
        .i_fade_steps(r_fade_steps),
        .i_fade_col  (fade_col),
        .o_cmd       (cmd),
        .o_addr      (addr),
        .o_wr_col    (wr_col),
        .o_frame     (frame),
        .o_fade_in   (fade_in),
        .i_stat      (stat),
        .i_rd_col    (rd_col)
    );

    pfe_datapath #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_addr    (addr),
        .i_wr_col  (wr_col),
        .i_frame   (frame),
        .i_steps   (r_fade_steps),
        .i_fade_in (fade_in),
        .i_fade_col(fade_col),
        .o_stat    (stat),
        .o_rd_col  (rd_col)
    );

endmodule

`default_nettype wire

/* sv/pfe_checker.sv */
// Port-level checker of the palette fade engine and its bind to the top level.
// Depends on pfe_pkg.
`default_nettype none

module pfe_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_ready,
    input wire pfe_pkg::t_in_word              i_in_word,
    input wire logic                           o_valid,
    input wire logic                           i_ready,
    input wire pfe_pkg::t_out_word             o_out_word,
    input wire logic                           i_cfg_we,
    input wire logic [pfe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input wire logic [pfe_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(i_ready))
        else $error("result word withdrawn without being taken");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(i_valid))
        else $error("ready dropped without an accepted word");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("outputs not idle after reset");

endmodule

bind palette_fade_engine_top pfe_checker u_pfe_checker (.*);

`default_nettype wire
